// ===== design/spmq_pkg.sv =====
// ----------------------------------------------------------------------------
// spmq_pkg
// Shared widths, codes and types of the stable priority move queue.
// ----------------------------------------------------------------------------
package spmq_pkg;

   localparam int OP_W  = 1;
   localparam int LVL_W = 3;
   localparam int MV_W  = 3;
   localparam int POS_W = 6;

   localparam logic [OP_W-1:0] OP_PUSH   = 1'b0;
   localparam logic [OP_W-1:0] OP_REPLAY = 1'b1;

   localparam logic [LVL_W-1:0] LVL_UNRECOGNIZED = 3'd0;
   localparam logic [LVL_W-1:0] LVL_CRITICAL     = 3'd1;
   localparam logic [LVL_W-1:0] LVL_HIGH         = 3'd2;
   localparam logic [LVL_W-1:0] LVL_NORMAL       = 3'd3;
   localparam logic [LVL_W-1:0] LVL_LOW          = 3'd4;

   localparam logic [MV_W-1:0] MV_UP    = 3'd1;
   localparam logic [MV_W-1:0] MV_RIGHT = 3'd2;
   localparam logic [MV_W-1:0] MV_DOWN  = 3'd3;
   localparam logic [MV_W-1:0] MV_LEFT  = 3'd4;

   localparam logic KIND_ACK = 1'b0;
   localparam logic KIND_POS = 1'b1;

   localparam logic STATUS_STORED = 1'b0;
   localparam logic STATUS_FULL   = 1'b1;

   localparam logic [POS_W-1:0] POS_MAX = 6'd63;

   typedef struct packed {
      logic [LVL_W-1:0] level;
      logic [MV_W-1:0]  move;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic             kind;
      logic             status;
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
      logic             last;
   } result_type;

endpackage

// ===== design/spmq_ram.sv =====
// ----------------------------------------------------------------------------
// spmq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module spmq_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // Read data holds until the next read is issued.
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/spmq_out.sv =====
// ----------------------------------------------------------------------------
// spmq_out
// Output register for result items, decoupling the sequencer from the
// result channel's stall.
// ----------------------------------------------------------------------------
module spmq_out (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  spmq_pkg::result_type           data,
   output logic                           slot_free,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_result_kind,
   output logic                           rsp_push_status,
   output logic [spmq_pkg::POS_W-1:0]     rsp_pos_x,
   output logic [spmq_pkg::POS_W-1:0]     rsp_pos_y,
   output logic                           rsp_last
);

   logic                 valid_ff;
   logic                 valid_in;
   spmq_pkg::result_type data_ff;

   assign slot_free = !valid_ff || !rsp_stall;
   assign valid_in  = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_result_kind = data_ff.kind;
   assign rsp_push_status = data_ff.status;
   assign rsp_pos_x       = data_ff.x;
   assign rsp_pos_y       = data_ff.y;
   assign rsp_last        = data_ff.last;

endmodule

// ===== design/stable_priority_move_queue.sv =====
// ----------------------------------------------------------------------------
// stable_priority_move_queue
// Bounded queue of move codes kept stably sorted by priority level, with a
// replay that walks the queue and reports the position after every move.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | operation, priority_level, move_code
//  rsp     | out       | rsp_valid/rsp_stall  | result_kind, push_status, pos_x, pos_y, last
//
// A push holds the input while each stored entry of less urgent level moves one place
// up; each step is a read and a write-back of the entry RAM, and the new entry is then
// written into the freed place. A push to a full queue is dropped and acknowledged as full.
// A replay reads each stored entry from the RAM, then updates the position; an empty
// replay reports the origin once. Reset clears the state and the entry count; the RAM
// needs no clearing pass. A stalled result waits in the output register; the
// sequencer waits only when it needs that register for the next result.
module stable_priority_move_queue #(
   parameter int CAPACITY = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [spmq_pkg::OP_W-1:0]      req_operation,
   input  logic [spmq_pkg::LVL_W-1:0]     req_priority_level,
   input  logic [spmq_pkg::MV_W-1:0]      req_move_code,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_result_kind,
   output logic                           rsp_push_status,
   output logic [spmq_pkg::POS_W-1:0]     rsp_pos_x,
   output logic [spmq_pkg::POS_W-1:0]     rsp_pos_y,
   output logic                           rsp_last
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PSTEP = 3'd1;
   localparam logic [2:0] S_PCMP  = 3'd2;
   localparam logic [2:0] S_ACK   = 3'd3;
   localparam logic [2:0] S_RREAD = 3'd4;
   localparam logic [2:0] S_RDATA = 3'd5;

   logic [2:0]                   state_ff, state_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [CW-1:0]                idx_ff, idx_in;
   logic [spmq_pkg::LVL_W-1:0]   lvl_ff, lvl_in;
   logic [spmq_pkg::MV_W-1:0]    mv_ff, mv_in;
   logic [spmq_pkg::POS_W-1:0]   x_ff, x_in;
   logic [spmq_pkg::POS_W-1:0]   y_ff, y_in;
   logic                         kind_ff, kind_in;
   logic                         status_ff, status_in;

   logic [CW-1:0]                idx_dec;
   logic [CW-1:0]                idx_inc;
   logic [spmq_pkg::LVL_W-1:0]   lvl_norm;
   logic                         accept;

   logic                         ram_wr_en;
   logic [AW-1:0]                ram_wr_addr;
   spmq_pkg::entry_type          ram_wr_data;
   logic                         ram_rd_en;
   logic [AW-1:0]                ram_rd_addr;
   spmq_pkg::entry_type          ram_rd_data;

   logic                         out_load;
   logic                         out_free;
   spmq_pkg::result_type         out_data;

   logic [spmq_pkg::POS_W-1:0]   step_x;
   logic [spmq_pkg::POS_W-1:0]   step_y;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign idx_dec   = idx_ff - CW'(1);
   assign idx_inc   = idx_ff + CW'(1);
   assign lvl_norm  = (req_priority_level > spmq_pkg::LVL_LOW) ?
                      spmq_pkg::LVL_UNRECOGNIZED : req_priority_level;

   // Position after the move read from the RAM.
   always_comb begin
      step_x = x_ff;
      step_y = y_ff;
      case (ram_rd_data.move)
         spmq_pkg::MV_UP: begin
            if (y_ff != spmq_pkg::POS_MAX) step_y = y_ff + 1'b1;
         end
         spmq_pkg::MV_RIGHT: begin
            if (x_ff != spmq_pkg::POS_MAX) step_x = x_ff + 1'b1;
         end
         spmq_pkg::MV_DOWN: begin
            if (y_ff != '0) step_y = y_ff - 1'b1;
         end
         spmq_pkg::MV_LEFT: begin
            if (x_ff != '0) step_x = x_ff - 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      lvl_in      = lvl_ff;
      mv_in       = mv_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      kind_in     = kind_ff;
      status_in   = status_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff[AW-1:0];
      ram_wr_data = '{level: lvl_ff, move: mv_ff};
      ram_rd_en   = 1'b0;
      ram_rd_addr = idx_ff[AW-1:0];
      out_load    = 1'b0;
      out_data    = '{kind: kind_ff, status: status_ff, x: '0, y: '0, last: 1'b1};

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               lvl_in    = lvl_norm;
               mv_in     = req_move_code;
               x_in      = '0;
               y_in      = '0;
               status_in = spmq_pkg::STATUS_STORED;
               if (req_operation == spmq_pkg::OP_PUSH) begin
                  kind_in = spmq_pkg::KIND_ACK;
                  if (count_ff == CW'(CAPACITY)) begin
                     status_in = spmq_pkg::STATUS_FULL;
                     state_in  = S_ACK;
                  end else begin
                     idx_in   = count_ff;
                     state_in = S_PSTEP;
                  end
               end else begin
                  kind_in = spmq_pkg::KIND_POS;
                  idx_in  = '0;
                  // An empty replay reports the origin once.
                  state_in = (count_ff == '0) ? S_ACK : S_RREAD;
               end
            end
         end
         S_PSTEP: begin
            if (idx_ff == '0) begin
               ram_wr_en = 1'b1;
               count_in  = count_ff + CW'(1);
               state_in  = S_ACK;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_dec[AW-1:0];
               state_in    = S_PCMP;
            end
         end
         S_PCMP: begin
            // Entries of a less urgent level move up one place; the new entry
            // lands right after the last one of equal or more urgent level.
            ram_wr_en = 1'b1;
            if (ram_rd_data.level > lvl_ff) begin
               ram_wr_data = ram_rd_data;
               idx_in      = idx_dec;
               state_in    = S_PSTEP;
            end else begin
               count_in = count_ff + CW'(1);
               state_in = S_ACK;
            end
         end
         S_ACK: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_RREAD: begin
            ram_rd_en = 1'b1;
            state_in  = S_RDATA;
         end
         S_RDATA: begin
            if (out_free) begin
               out_load = 1'b1;
               out_data = '{kind: spmq_pkg::KIND_POS, status: spmq_pkg::STATUS_STORED,
                            x: step_x, y: step_y, last: (idx_inc == count_ff)};
               x_in     = step_x;
               y_in     = step_y;
               idx_in   = idx_inc;
               state_in = (idx_inc == count_ff) ? S_IDLE : S_RREAD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      lvl_ff    <= lvl_in;
      mv_ff     <= mv_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      kind_ff   <= kind_in;
      status_ff <= status_in;
   end

   spmq_ram #(
      .WIDTH (spmq_pkg::ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   spmq_out u_out (
      .clock           (clock),
      .reset           (reset),
      .load            (out_load),
      .data            (out_data),
      .slot_free       (out_free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_push_status (rsp_push_status),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_last        (rsp_last)
   );

endmodule

// ===== design/spmq_check.sv =====
// ----------------------------------------------------------------------------
// spmq_check
// Port-level checks of the stable priority move queue.
// ----------------------------------------------------------------------------
module spmq_check (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic                        rsp_result_kind,
   input logic                        rsp_push_status,
   input logic [spmq_pkg::POS_W-1:0]  rsp_pos_x,
   input logic [spmq_pkg::POS_W-1:0]  rsp_pos_y,
   input logic                        rsp_last
);

   // A stalled result stays offered unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pos_x) && $stable(rsp_pos_y)
         && $stable(rsp_last) && $stable(rsp_result_kind))
      else $error("stalled result changed");

   // The block works on one item at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item accepted while another is in progress");

   // A push gives exactly one result, at the origin.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == spmq_pkg::KIND_ACK |->
         rsp_last && rsp_pos_x == '0 && rsp_pos_y == '0)
      else $error("malformed push acknowledgement");

   // A replay position never carries the full flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == spmq_pkg::KIND_POS |->
         rsp_push_status == spmq_pkg::STATUS_STORED)
      else $error("replay position flagged as dropped push");

endmodule

bind stable_priority_move_queue spmq_check u_check (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_result_kind (rsp_result_kind),
   .rsp_push_status (rsp_push_status),
   .rsp_pos_x       (rsp_pos_x),
   .rsp_pos_y       (rsp_pos_y),
   .rsp_last        (rsp_last)
);

// ===== bench/spmq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmq_checker
// Watches both channels of the stable priority move queue. It keeps its own
// copy of the sorted queue, works out the results of every accepted item,
// and compares each accepted result with the oldest one still owed.
// ----------------------------------------------------------------------------
module spmq_checker #(
   parameter int CAPACITY = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [spmq_pkg::OP_W-1:0]  req_operation,
   input  logic [spmq_pkg::LVL_W-1:0] req_priority_level,
   input  logic [spmq_pkg::MV_W-1:0]  req_move_code,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic                       rsp_result_kind,
   input  logic                       rsp_push_status,
   input  logic [spmq_pkg::POS_W-1:0] rsp_pos_x,
   input  logic [spmq_pkg::POS_W-1:0] rsp_pos_y,
   input  logic                       rsp_last,
   output int                         mismatch_count,
   output int                         results_owed
);

   spmq_pkg::entry_type  queued_moves [CAPACITY];
   int                   queued_count;
   spmq_pkg::result_type owed_results [$];

   task automatic insert_move(input logic [spmq_pkg::LVL_W-1:0] level,
                              input logic [spmq_pkg::MV_W-1:0] move);
      spmq_pkg::result_type       ack;
      logic [spmq_pkg::LVL_W-1:0] rank;
      int                         slot;
      ack = '{kind: spmq_pkg::KIND_ACK, status: spmq_pkg::STATUS_STORED, x: '0, y: '0,
              last: 1'b1};
      // Levels beyond low sort together with the unrecognized ones.
      rank = (level > spmq_pkg::LVL_LOW) ? spmq_pkg::LVL_UNRECOGNIZED : level;
      if (queued_count >= CAPACITY) begin
         ack.status = spmq_pkg::STATUS_FULL;
      end else begin
         slot = 0;
         while (slot < queued_count && queued_moves[slot].level <= rank) slot++;
         for (int i = queued_count; i > slot; i--) queued_moves[i] = queued_moves[i-1];
         queued_moves[slot] = '{level: rank, move: move};
         queued_count++;
      end
      owed_results.push_back(ack);
   endtask

   task automatic walk_moves();
      spmq_pkg::result_type       step;
      logic [spmq_pkg::POS_W-1:0] x;
      logic [spmq_pkg::POS_W-1:0] y;
      x = '0;
      y = '0;
      if (queued_count == 0) begin
         owed_results.push_back('{kind: spmq_pkg::KIND_POS, status: spmq_pkg::STATUS_STORED,
                                  x: '0, y: '0, last: 1'b1});
      end
      for (int i = 0; i < queued_count; i++) begin
         case (queued_moves[i].move)
            spmq_pkg::MV_UP:    if (y != spmq_pkg::POS_MAX) y = y + 1'b1;
            spmq_pkg::MV_RIGHT: if (x != spmq_pkg::POS_MAX) x = x + 1'b1;
            spmq_pkg::MV_DOWN:  if (y != '0) y = y - 1'b1;
            spmq_pkg::MV_LEFT:  if (x != '0) x = x - 1'b1;
            default: ;
         endcase
         step = '{kind: spmq_pkg::KIND_POS, status: spmq_pkg::STATUS_STORED, x: x, y: y,
                  last: (i == queued_count - 1)};
         owed_results.push_back(step);
      end
   endtask

   task automatic check_field(input string field_name,
                              input logic [spmq_pkg::POS_W-1:0] want,
                              input logic [spmq_pkg::POS_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field_name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic check_result();
      spmq_pkg::result_type want;
      if (owed_results.size() == 0) begin
         $error("result arrived with none expected");
         mismatch_count++;
         return;
      end
      want = owed_results.pop_front();
      check_field("result_kind", want.kind, rsp_result_kind);
      check_field("push_status", want.status, rsp_push_status);
      check_field("pos_x", want.x, rsp_pos_x);
      check_field("pos_y", want.y, rsp_pos_y);
      check_field("last", want.last, rsp_last);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         queued_count = 0;
         owed_results.delete();
      end else begin
         if (req_valid && !req_stall) begin
            if (req_operation == spmq_pkg::OP_PUSH) begin
               insert_move(req_priority_level, req_move_code);
            end else begin
               walk_moves();
            end
         end
         if (rsp_valid && !rsp_stall) check_result();
      end
      results_owed = owed_results.size();
   end

endmodule

// ===== bench/tb_stable_priority_move_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stable_priority_move_queue
// Drives pushes and replays into the stable priority move queue: a directed
// walk from an empty queue up to a full one, then random items under several
// idle and stall mixes, including one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_stable_priority_move_queue;

   localparam int CAPACITY     = 16;
   localparam int RANDOM_ITEMS = 188;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_OFF     = 400;

   // Codes outside the named ranges of the package.
   localparam logic [spmq_pkg::LVL_W-1:0] LVL_BEYOND_LO  = 3'd5;
   localparam logic [spmq_pkg::LVL_W-1:0] LVL_BEYOND_MID = 3'd6;
   localparam logic [spmq_pkg::LVL_W-1:0] LVL_BEYOND_HI  = 3'd7;
   localparam logic [spmq_pkg::MV_W-1:0]  MV_NONE        = 3'd0;
   localparam logic [spmq_pkg::MV_W-1:0]  MV_BEYOND_LO   = 3'd5;
   localparam logic [spmq_pkg::MV_W-1:0]  MV_BEYOND_MID  = 3'd6;
   localparam logic [spmq_pkg::MV_W-1:0]  MV_BEYOND_HI   = 3'd7;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [spmq_pkg::OP_W-1:0]    req_operation = spmq_pkg::OP_PUSH;
   logic [spmq_pkg::LVL_W-1:0]   req_priority_level = spmq_pkg::LVL_UNRECOGNIZED;
   logic [spmq_pkg::MV_W-1:0]    req_move_code = MV_NONE;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic                         rsp_result_kind;
   logic                         rsp_push_status;
   logic [spmq_pkg::POS_W-1:0]   rsp_pos_x;
   logic [spmq_pkg::POS_W-1:0]   rsp_pos_y;
   logic                         rsp_last;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int hold_cycles        = 0;
   int cycle_count        = 0;
   int mismatch_count;
   int results_owed;

   stable_priority_move_queue #(.CAPACITY(CAPACITY)) uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_priority_level (req_priority_level),
      .req_move_code      (req_move_code),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_push_status    (rsp_push_status),
      .rsp_pos_x          (rsp_pos_x),
      .rsp_pos_y          (rsp_pos_y),
      .rsp_last           (rsp_last)
   );

   spmq_checker #(.CAPACITY(CAPACITY)) u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_priority_level (req_priority_level),
      .req_move_code      (req_move_code),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_push_status    (rsp_push_status),
      .rsp_pos_x          (rsp_pos_x),
      .rsp_pos_y          (rsp_pos_y),
      .rsp_last           (rsp_last),
      .mismatch_count     (mismatch_count),
      .results_owed       (results_owed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("stable_priority_move_queue: mismatch");
         $finish;
      end
   end

   // The receiver either sits out a requested hold-off or stalls at random.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall = 1'b1;
         hold_cycles = hold_cycles - 1;
      end else begin
         rsp_stall = ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // Called and returning at a falling edge; the item stays offered until taken.
   task automatic send_item(input logic [spmq_pkg::OP_W-1:0] op,
                            input logic [spmq_pkg::LVL_W-1:0] level,
                            input logic [spmq_pkg::MV_W-1:0] move);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_operation = op;
      req_priority_level = level;
      req_move_code = move;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      logic [spmq_pkg::OP_W-1:0] op;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // Directed walk: an empty replay, then fill the queue to capacity with
      // every level and move code, with replays at points along the way.
      send_item(spmq_pkg::OP_REPLAY, spmq_pkg::LVL_UNRECOGNIZED, MV_NONE);
      send_item(spmq_pkg::OP_PUSH, spmq_pkg::LVL_LOW, spmq_pkg::MV_UP);
      send_item(spmq_pkg::OP_PUSH, spmq_pkg::LVL_UNRECOGNIZED, spmq_pkg::MV_DOWN);
      send_item(spmq_pkg::OP_PUSH, LVL_BEYOND_HI, spmq_pkg::MV_LEFT);
      send_item(spmq_pkg::OP_REPLAY, LVL_BEYOND_HI, MV_BEYOND_HI);
      send_item(spmq_pkg::OP_PUSH, spmq_pkg::LVL_CRITICAL, spmq_pkg::MV_RIGHT);
      send_item(spmq_pkg::OP_PUSH, spmq_pkg::LVL_HIGH, spmq_pkg::MV_UP);
      send_item(spmq_pkg::OP_PUSH, spmq_pkg::LVL_NORMAL, MV_NONE);
      send_item(spmq_pkg::OP_PUSH, LVL_BEYOND_LO, MV_BEYOND_HI);
      send_item(spmq_pkg::OP_PUSH, LVL_BEYOND_MID, MV_BEYOND_LO);
      send_item(spmq_pkg::OP_PUSH, spmq_pkg::LVL_LOW, spmq_pkg::MV_RIGHT);
      send_item(spmq_pkg::OP_PUSH, spmq_pkg::LVL_CRITICAL, MV_BEYOND_MID);
      send_item(spmq_pkg::OP_REPLAY, spmq_pkg::LVL_CRITICAL, spmq_pkg::MV_UP);
      send_item(spmq_pkg::OP_PUSH, spmq_pkg::LVL_HIGH, spmq_pkg::MV_LEFT);
      send_item(spmq_pkg::OP_PUSH, spmq_pkg::LVL_NORMAL, spmq_pkg::MV_DOWN);
      send_item(spmq_pkg::OP_PUSH, spmq_pkg::LVL_UNRECOGNIZED, spmq_pkg::MV_UP);
      send_item(spmq_pkg::OP_PUSH, spmq_pkg::LVL_CRITICAL, spmq_pkg::MV_RIGHT);
      send_item(spmq_pkg::OP_PUSH, spmq_pkg::LVL_LOW, spmq_pkg::MV_UP);
      send_item(spmq_pkg::OP_PUSH, spmq_pkg::LVL_HIGH, spmq_pkg::MV_RIGHT);
      send_item(spmq_pkg::OP_PUSH, spmq_pkg::LVL_NORMAL, spmq_pkg::MV_LEFT);
      send_item(spmq_pkg::OP_PUSH, spmq_pkg::LVL_UNRECOGNIZED, spmq_pkg::MV_UP);
      send_item(spmq_pkg::OP_REPLAY, spmq_pkg::LVL_LOW, spmq_pkg::MV_DOWN);
      send_item(spmq_pkg::OP_REPLAY, spmq_pkg::LVL_UNRECOGNIZED, MV_NONE);

      // The queue is now full for good, so random pushes are all dropped and
      // every replay walks the whole queue.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
               hold_cycles = HOLD_OFF;
            end
            1: begin
               sender_idle_pct = 86;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 86;
            end
            default: begin
               sender_idle_pct = 26;
               receiver_stall_pct = 26;
            end
         endcase
         for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
            op = ($urandom_range(99) < 35) ? spmq_pkg::OP_REPLAY : spmq_pkg::OP_PUSH;
            send_item(op, spmq_pkg::LVL_W'($urandom_range(7)),
                      spmq_pkg::MV_W'($urandom_range(7)));
         end
      end
      req_valid = 1'b0;

      while (results_owed != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("stable_priority_move_queue: match");
      end else begin
         $display("stable_priority_move_queue: mismatch");
      end
      $finish;
   end

endmodule
